### sv/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### sv/mclp_pkg.sv
// shared types and constants of the click detector
`timescale 1ns / 1ps

package mclp_pkg;

  localparam int unsigned TICK_W  = 16;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  localparam logic [TICK_W-1:0]  TICK_MAX  = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [TICK_W-1:0] CLICK_WINDOW_RST = 16'd350;
  localparam logic [TICK_W-1:0] HOLD_TIME_RST    = 16'd2000;

  localparam logic [COUNT_W-1:0] LONG_PRESS_CODE = '0;

  // register index taken from paddr[2]
  localparam logic REG_CLICK_WINDOW = 1'b0;
  localparam logic REG_HOLD_TIME    = 1'b1;

  typedef struct packed {
    logic [TICK_W-1:0] click_window;
    logic [TICK_W-1:0] hold_time;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic [COUNT_W-1:0] click_count;
  } res_t;

endpackage

### sv/mclp_ifs.sv
// request and result channel interfaces
`timescale 1ns / 1ps

interface mclp_in_if;
  logic valid;
  logic ready;
  logic pressed;
  modport src (output valid, output pressed, input ready);
  modport snk (input valid, input pressed, output ready);
endinterface

interface mclp_out_if;
  logic                         valid;
  logic                         ready;
  logic [mclp_pkg::COUNT_W-1:0] click_count;
  modport src (output valid, output click_count, input ready);
  modport snk (input valid, input click_count, output ready);
endinterface

### sv/multi_click_long_press_detector.sv
// top level of the multi-click and long-press detector
// Each request is one tick carrying the button level; the block takes one request per
// clock cycle while in_req.ready is high, and decides within that cycle whether the tick
// ends a click sequence, so a result (a click count, or 0 for a long press) is pushed into the queue.
// Results wait in a two-entry output queue; in_req.ready drops only while both entries
// are occupied. Registers: click_window at byte address 0, hold_time at byte address 4,
// both 16 bits in the low half of the 32-bit word; write them only while the block is idle.
`timescale 1ns / 1ps

module multi_click_long_press_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  mclp_in_if.snk                        in_req,
  mclp_out_if.src                       out_res,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [mclp_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [mclp_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [mclp_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  mclp_pkg::cfg_t cfg_r;
  mclp_pkg::res_t res;
  logic           has_room;
  logic           step;
  logic           wr_en;
  logic           reg_idx;

  assign reg_idx    = cfg_paddr[2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    case (reg_idx)
      mclp_pkg::REG_CLICK_WINDOW: cfg_prdata = mclp_pkg::DATA_W'(cfg_r.click_window);
      mclp_pkg::REG_HOLD_TIME:    cfg_prdata = mclp_pkg::DATA_W'(cfg_r.hold_time);
      default:                    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.click_window <= mclp_pkg::CLICK_WINDOW_RST;
      cfg_r.hold_time    <= mclp_pkg::HOLD_TIME_RST;
    end else if (wr_en) begin
      case (reg_idx)
        mclp_pkg::REG_CLICK_WINDOW: cfg_r.click_window <= cfg_pwdata[mclp_pkg::TICK_W-1:0];
        mclp_pkg::REG_HOLD_TIME:    cfg_r.hold_time    <= cfg_pwdata[mclp_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_req.ready = has_room;
  assign step         = in_req.valid && has_room;

  mclp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .pressed (in_req.pressed),
    .cfg     (cfg_r),
    .res     (res)
  );

  mclp_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res),
    .has_room (has_room),
    .out_res  (out_res)
  );

endmodule

### sv/mclp_core.sv
// per-tick level history, click counting and dispatch decision
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mclp_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic            pressed,
  input  mclp_pkg::cfg_t  cfg,
  output mclp_pkg::res_t  res
);

  logic                         prev_r;
  logic [mclp_pkg::TICK_W-1:0]  tsc_r;
  logic [mclp_pkg::TICK_W-1:0]  tsc_nxt;
  logic [mclp_pkg::COUNT_W-1:0] pc_r;
  logic [mclp_pkg::COUNT_W-1:0] pc_upd;
  logic [mclp_pkg::COUNT_W-1:0] pc_nxt;
  logic                         changed;
  logic                         quiet;
  logic                         long_press;
  logic                         fire;

  always_comb begin
    changed = (pressed != prev_r);
    if (changed) begin
      tsc_nxt = '0;
    end else if (tsc_r == mclp_pkg::TICK_MAX) begin
      tsc_nxt = tsc_r;
    end else begin
      tsc_nxt = tsc_r + 1'b1;
    end
    if (changed && pressed && (pc_r != mclp_pkg::COUNT_MAX)) begin
      pc_upd = pc_r + 1'b1;
    end else begin
      pc_upd = pc_r;
    end
    quiet      = (pc_upd != '0) && (tsc_nxt >= cfg.click_window);
    long_press = pressed && (pc_upd == mclp_pkg::COUNT_W'(1)) && (tsc_nxt > cfg.hold_time);
    fire       = quiet && (!pressed || long_press);
    pc_nxt     = fire ? '0 : pc_upd;
    res.valid       = step && fire;
    res.click_count = pressed ? mclp_pkg::LONG_PRESS_CODE : pc_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= 1'b0;
      tsc_r  <= '0;
      pc_r   <= '0;
    end else if (step) begin
      prev_r <= pressed;
      tsc_r  <= tsc_nxt;
      pc_r   <= pc_nxt;
    end
  end

  `ASSERT_NXT(a_fire_clears, clk, rst_n, rst_n && res.valid, pc_r == '0,
    "pending count not cleared after report")
  `ASSERT_IMP(a_long_held, clk, rst_n,
    res.valid && (res.click_count == mclp_pkg::LONG_PRESS_CODE), pressed && !changed,
    "long press reported without a steady held level")
  `ASSERT_IMP(a_release_nonzero, clk, rst_n, res.valid && !pressed, res.click_count != '0,
    "release report with zero clicks")

endmodule

### sv/mclp_obuf.sv
// two-entry result queue between the tick logic and the result channel
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mclp_obuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mclp_pkg::res_t       push,
  output logic                 has_room,
  mclp_out_if.src              out_res
);

  logic [1:0]                   cnt_r;
  logic [1:0]                   cnt_nxt;
  logic [mclp_pkg::COUNT_W-1:0] e0_r;
  logic [mclp_pkg::COUNT_W-1:0] e0_nxt;
  logic [mclp_pkg::COUNT_W-1:0] e1_r;
  logic [mclp_pkg::COUNT_W-1:0] e1_nxt;
  logic                         pop;

  assign pop                 = (cnt_r != 2'd0) && out_res.ready;
  assign has_room            = (cnt_r != 2'd2);
  assign out_res.valid       = (cnt_r != 2'd0);
  assign out_res.click_count = e0_r;

  always_comb begin
    cnt_nxt = cnt_r;
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    if (pop && push.valid) begin
      if (cnt_r == 2'd2) begin
        e0_nxt = e1_r;
        e1_nxt = push.click_count;
      end else begin
        e0_nxt = push.click_count;
      end
    end else if (pop) begin
      e0_nxt  = e1_r;
      cnt_nxt = cnt_r - 2'd1;
    end else if (push.valid) begin
      if (cnt_r == 2'd0) begin
        e0_nxt = push.click_count;
      end else begin
        e1_nxt = push.click_count;
      end
      cnt_nxt = cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

  `ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_r != 2'd3, "queue count out of range")
  `ASSERT_IMP(a_no_overflow, clk, rst_n, push.valid, cnt_r != 2'd2, "push into full queue")
  `ASSERT_NXT(a_pop_dec, clk, rst_n, rst_n && pop && !push.valid,
    cnt_r == ($past(cnt_r) - 2'd1), "queue count not decremented on pop")

endmodule
